// ----- sv/ehpcd_pkg.sv -----
// Package for the ECG heart pulse and contact detector.
// Holds item codes, register indexes, field types and fixed limits.
// No dependencies.
package ehpcd_pkg;

    // Longest burst that is still classified and counted
    localparam logic [7:0] BURST_MAX = 8'd32;

    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 3;

    typedef logic [1:0]  op_t;
    typedef logic [23:0] word_t;
    typedef logic [16:0] interval_t;
    typedef logic [15:0] ms16_t;
    typedef logic signed [15:0] sample_t;
    typedef logic [1:0]  rhythm_t;
    typedef logic [3:0]  batch_t;
    typedef logic [31:0] time_t;
    typedef logic [7:0]  cnt8_t;
    typedef logic [15:0] cnt16_t;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_RTOR = 2'd1,
        OP_FIFO = 2'd2
    } op_code_t;

    typedef enum logic [2:0] {
        REG_MIN_INTERVAL  = 3'd0,
        REG_MAX_INTERVAL  = 3'd1,
        REG_PULSE_WIDTH   = 3'd2,
        REG_FAKE_INTERVAL = 3'd3,
        REG_BAND_TOP      = 3'd4,
        REG_BAND_BOTTOM   = 3'd5,
        REG_BATCH_SIZE    = 3'd6,
        REG_ON_MIN_COUNT  = 3'd7
    } cfg_reg_t;

    localparam rhythm_t RHY_UNSTABLE = 2'd0;
    localparam rhythm_t RHY_STABLE   = 2'd1;
    localparam rhythm_t RHY_UNKNOWN  = 2'd2;

    localparam logic [2:0] TAG_VALID    = 3'd0;
    localparam logic [2:0] TAG_FAST     = 3'd1;
    localparam logic [2:0] TAG_OVERFLOW = 3'd7;

endpackage

// ----- sv/ecg_heart_pulse_and_contact_detector_core.sv -----
// Top level of the ECG heart pulse and contact detector.
// Keeps time, pulse level, hand contact and rhythm status; one result per item.
// Depends on ehpcd_pkg.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  input   | in_valid, in_ready, op, rtor_word, fifo_word     | in
//  result  | out_valid, out_ready, pulse_level .. batch_done  | out
//  config  | cfg_we, cfg_index, cfg_data                      | in
//
// One item per clock while results are taken. All state updates at the transfer of an
// item; the result for that item sits in the output register in the next cycle.
// A new item transfers whenever the output register is empty or is being
// drained in the same cycle, so an item can follow every cycle.
// rst_n clears all state but the result payload and loads the register defaults; no clearing pass.
module ecg_heart_pulse_and_contact_detector_core (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  ehpcd_pkg::op_t                           op,
    input  ehpcd_pkg::word_t                         rtor_word,
    input  ehpcd_pkg::word_t                         fifo_word,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic                                     pulse_level,
    output logic                                     pulse_started,
    output ehpcd_pkg::interval_t                     pulse_interval_ms,
    output logic                                     contact_status,
    output ehpcd_pkg::rhythm_t                       rhythm_status,
    output ehpcd_pkg::sample_t                       sample_value,
    output logic                                     burst_end,
    output logic                                     fifo_reset,
    output logic                                     batch_done,
    input  logic                                     cfg_we,
    input  logic [ehpcd_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [ehpcd_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import ehpcd_pkg::*;

    // Configuration registers
    interval_t min_interval_reg;
    interval_t max_interval_reg;
    ms16_t     pulse_width_reg;
    ms16_t     fake_interval_reg;
    sample_t   band_top_reg;
    sample_t   band_bottom_reg;
    batch_t    batch_size_reg;
    cnt16_t    on_min_reg;

    // Block state
    time_t   now_reg, now_next;
    time_t   pulse_on_time_reg, pulse_on_time_next;
    time_t   last_rtor_reg, last_rtor_next;
    time_t   last_fake_reg, last_fake_next;
    logic    pulse_high_reg, pulse_high_next;
    logic    contact_reg, contact_next;
    rhythm_t stability_reg, stability_next;
    cnt16_t  on_total_reg, on_total_next;
    cnt16_t  off_total_reg, off_total_next;
    cnt8_t   burst_on_reg, burst_on_next;
    cnt8_t   burst_off_reg, burst_off_next;
    cnt8_t   burst_len_reg, burst_len_next;
    batch_t  burst_count_reg, burst_count_next;

    // Output register
    logic      out_valid_reg;
    logic      pulse_level_reg;
    logic      started_reg, started_next;
    interval_t interval_reg, interval_next;
    logic      contact_out_reg;
    rhythm_t   rhythm_reg;
    sample_t   sample_reg, sample_next;
    logic      burst_end_reg, burst_end_next;
    logic      fifo_reset_reg, fifo_reset_next;
    logic      batch_done_reg, batch_done_next;

    logic in_xfer;

    // Decode helpers
    time_t     since_rtor;
    time_t     since_fake;
    time_t     since_pulse;
    interval_t rtor_iv;
    logic      rtor_ok;
    logic [2:0] tag;
    sample_t   sample;
    logic [16:0] on_sum;
    logic [16:0] off_sum;
    logic [10:0] len_x5;
    logic [9:0]  thr;

    // Take a new item when the result slot is empty or drains this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg  <= 17'd500;
            max_interval_reg  <= 17'd1000;
            pulse_width_reg   <= 16'd200;
            fake_interval_reg <= 16'd833;
            band_top_reg      <= -16'sd8;
            band_bottom_reg   <= -16'sd25;
            batch_size_reg    <= 4'd5;
            on_min_reg        <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIN_INTERVAL:  min_interval_reg  <= cfg_data;
                REG_MAX_INTERVAL:  max_interval_reg  <= cfg_data;
                REG_PULSE_WIDTH:   pulse_width_reg   <= cfg_data[15:0];
                REG_FAKE_INTERVAL: fake_interval_reg <= cfg_data[15:0];
                REG_BAND_TOP:      band_top_reg      <= sample_t'(cfg_data[15:0]);
                REG_BAND_BOTTOM:   band_bottom_reg   <= sample_t'(cfg_data[15:0]);
                REG_BATCH_SIZE:    batch_size_reg    <= cfg_data[3:0];
                REG_ON_MIN_COUNT:  on_min_reg        <= cfg_data[15:0];
            endcase
        end
    end

    // Item processing: one pass from current state to next state and result
    always_comb
    begin
        now_next           = now_reg;
        pulse_on_time_next = pulse_on_time_reg;
        last_rtor_next     = last_rtor_reg;
        last_fake_next     = last_fake_reg;
        pulse_high_next    = pulse_high_reg;
        contact_next       = contact_reg;
        stability_next     = stability_reg;
        on_total_next      = on_total_reg;
        off_total_next     = off_total_reg;
        burst_on_next      = burst_on_reg;
        burst_off_next     = burst_off_reg;
        burst_len_next     = burst_len_reg;
        burst_count_next   = burst_count_reg;

        started_next    = 1'b0;
        interval_next   = '0;
        sample_next     = '0;
        burst_end_next  = 1'b0;
        fifo_reset_next = 1'b0;
        batch_done_next = 1'b0;

        // Tick timing: all differences wrap at 32 bits
        since_rtor  = now_reg + 32'd1 - last_rtor_reg;
        since_fake  = now_reg + 32'd1 - last_fake_reg;
        since_pulse = '0;

        // R-to-R interval in ms is the 14-bit count times eight
        rtor_iv = {rtor_word[23:10], 3'b000};
        rtor_ok = (rtor_iv >= min_interval_reg) && (rtor_iv <= max_interval_reg);

        tag    = fifo_word[5:3];
        sample = sample_t'(fifo_word[23:8]);
        on_sum  = '0;
        off_sum = '0;
        len_x5  = '0;
        thr     = '0;

        unique case (op_code_t'(op))
            OP_TICK:
            begin
                now_next = now_reg + 32'd1;
                if (contact_reg && (since_rtor > {15'd0, max_interval_reg})
                    && (since_fake > {16'd0, fake_interval_reg}) && !pulse_high_reg)
                begin
                    // Fill in a fake pulse after a long silence
                    stability_next     = RHY_UNSTABLE;
                    last_fake_next     = now_next;
                    pulse_high_next    = 1'b1;
                    pulse_on_time_next = now_next;
                    started_next       = 1'b1;
                    interval_next      = {1'b0, fake_interval_reg};
                end
                else if (!contact_reg)
                begin
                    stability_next = RHY_UNKNOWN;
                end
                // Drop the pulse once its width has elapsed
                since_pulse = now_next - pulse_on_time_next;
                if (since_pulse >= {16'd0, pulse_width_reg})
                begin
                    pulse_high_next = 1'b0;
                end
            end
            OP_RTOR:
            begin
                if (rtor_ok)
                begin
                    last_rtor_next = now_reg;
                    if (contact_reg)
                    begin
                        stability_next     = RHY_STABLE;
                        pulse_high_next    = 1'b1;
                        pulse_on_time_next = now_reg;
                        started_next       = 1'b1;
                        interval_next      = rtor_iv;
                    end
                end
            end
            OP_FIFO:
            begin
                sample_next = sample;
                // Classify only until the burst length saturates
                if (burst_len_reg < BURST_MAX)
                begin
                    burst_len_next = burst_len_reg + 8'd1;
                    if ((sample >= band_top_reg) || (sample <= band_bottom_reg))
                        burst_on_next = burst_on_reg + 8'd1;
                    else
                        burst_off_next = burst_off_reg + 8'd1;
                end
                if ((tag != TAG_VALID) && (tag != TAG_FAST))
                begin
                    burst_end_next  = 1'b1;
                    fifo_reset_next = (tag == TAG_OVERFLOW);
                    // Fold in burst counts, saturating at full scale
                    on_sum  = {1'b0, on_total_reg}  + {9'd0, burst_on_next};
                    off_sum = {1'b0, off_total_reg} + {9'd0, burst_off_next};
                    if (burst_len_next > 8'd1)
                    begin
                        on_total_next  = on_sum[16]  ? 16'hFFFF : on_sum[15:0];
                        off_total_next = off_sum[16] ? 16'hFFFF : off_sum[15:0];
                    end
                    burst_count_next = burst_count_reg + 4'd1;
                    if (burst_count_next >= batch_size_reg)
                    begin
                        // Off threshold is floor(5/2 of the last burst length)
                        len_x5 = {1'b0, burst_len_next, 2'b00} + {3'd0, burst_len_next};
                        thr    = len_x5[10:1];
                        contact_next = (on_total_next > on_min_reg)
                                       && (off_total_next > {6'd0, thr});
                        on_total_next    = '0;
                        off_total_next   = '0;
                        burst_count_next = '0;
                        batch_done_next  = 1'b1;
                    end
                    burst_on_next  = '0;
                    burst_off_next = '0;
                    burst_len_next = '0;
                end
            end
            default:
            begin
                // Unused code: hold all state and report it
            end
        endcase
    end

    // State registers advance only on an input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg           <= '0;
            pulse_on_time_reg <= '0;
            last_rtor_reg     <= '0;
            last_fake_reg     <= '0;
            pulse_high_reg    <= 1'b0;
            contact_reg       <= 1'b0;
            stability_reg     <= RHY_UNKNOWN;
            on_total_reg      <= '0;
            off_total_reg     <= '0;
            burst_on_reg      <= '0;
            burst_off_reg     <= '0;
            burst_len_reg     <= '0;
            burst_count_reg   <= '0;
        end
        else if (in_xfer)
        begin
            now_reg           <= now_next;
            pulse_on_time_reg <= pulse_on_time_next;
            last_rtor_reg     <= last_rtor_next;
            last_fake_reg     <= last_fake_next;
            pulse_high_reg    <= pulse_high_next;
            contact_reg       <= contact_next;
            stability_reg     <= stability_next;
            on_total_reg      <= on_total_next;
            off_total_reg     <= off_total_next;
            burst_on_reg      <= burst_on_next;
            burst_off_reg     <= burst_off_next;
            burst_len_reg     <= burst_len_next;
            burst_count_reg   <= burst_count_next;
        end
    end

    // Result valid: set on input transfer, clear when taken without refill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload: load with each input transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pulse_level_reg <= pulse_high_next;
            started_reg     <= started_next;
            interval_reg    <= interval_next;
            contact_out_reg <= contact_next;
            rhythm_reg      <= stability_next;
            sample_reg      <= sample_next;
            burst_end_reg   <= burst_end_next;
            fifo_reset_reg  <= fifo_reset_next;
            batch_done_reg  <= batch_done_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign pulse_level       = pulse_level_reg;
    assign pulse_started     = started_reg;
    assign pulse_interval_ms = interval_reg;
    assign contact_status    = contact_out_reg;
    assign rhythm_status     = rhythm_reg;
    assign sample_value      = sample_reg;
    assign burst_end         = burst_end_reg;
    assign fifo_reset        = fifo_reset_reg;
    assign batch_done        = batch_done_reg;

endmodule

// ----- sim/ecg_heart_pulse_and_contact_detector_core_tb.sv -----
// Self-checking testbench for the ECG heart pulse and contact detector core.
// Predicts every result from its own copy of the detector state and checks each transfer.
// Depends on ehpcd_pkg and ecg_heart_pulse_and_contact_detector_core.
module ecg_heart_pulse_and_contact_detector_core_tb;
    import ehpcd_pkg::*;

    // Spare op code: the block must leave its state alone and report it
    localparam op_t OP_SPARE   = 2'd3;
    // Cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT = 2000;

    // One result of the block, field by field
    typedef struct {
        logic      pulse_level;
        logic      pulse_started;
        interval_t interval;
        logic      contact_status;
        rhythm_t   rhythm;
        sample_t   sample;
        logic      burst_end;
        logic      fifo_reset;
        logic      batch_done;
    } status_t;

    // Tracks pulse timing, burst counts and hand contact; keeps the expected
    // status of every accepted item until its result transfers.
    class contact_pulse_tracker;
        interval_t min_iv   = 17'd500;
        interval_t max_iv   = 17'd1000;
        ms16_t     width    = 16'd200;
        ms16_t     fake_gap = 16'd833;
        sample_t   top      = -16'sd8;
        sample_t   bottom   = -16'sd25;
        batch_t    batch    = 4'd5;
        cnt16_t    min_on   = 16'd1;

        time_t   now       = '0;
        time_t   pulse_t0  = '0;
        time_t   last_rtor = '0;
        time_t   last_fake = '0;
        logic    pulse_high = 1'b0;
        logic    contact    = 1'b0;
        rhythm_t rhythm     = RHY_UNKNOWN;
        cnt16_t  on_total  = '0;
        cnt16_t  off_total = '0;
        cnt8_t   burst_on  = '0;
        cnt8_t   burst_off = '0;
        cnt8_t   burst_len = '0;
        batch_t  bursts    = '0;

        status_t expected_status[$];
        int errors, checked, items, pulses, fakes, decisions, contact_on;

        function void set_reg(cfg_reg_t idx, logic [16:0] v);
            case (idx)
                REG_MIN_INTERVAL:  min_iv   = v;
                REG_MAX_INTERVAL:  max_iv   = v;
                REG_PULSE_WIDTH:   width    = v[15:0];
                REG_FAKE_INTERVAL: fake_gap = v[15:0];
                REG_BAND_TOP:      top      = v[15:0];
                REG_BAND_BOTTOM:   bottom   = v[15:0];
                REG_BATCH_SIZE:    batch    = v[3:0];
                REG_ON_MIN_COUNT:  min_on   = v[15:0];
                default: ;
            endcase
        endfunction

        function cnt16_t sat_add(cnt16_t a, cnt8_t b);
            logic [16:0] s;
            s = a + b;
            return s[16] ? 16'hFFFF : s[15:0];
        endfunction

        function void start_pulse(inout status_t r, input interval_t iv);
            pulse_high      = 1'b1;
            pulse_t0        = now;
            r.pulse_started = 1'b1;
            r.interval      = iv;
            pulses++;
        endfunction

        function void take_item(op_t o, word_t rw, word_t fw);
            status_t     r;
            interval_t   iv;
            logic [2:0]  tag;
            int unsigned thr;
            r = '{default: '0};
            items++;
            case (o)
                OP_TICK: begin
                    now = now + 1;
                    if (contact && (now - last_rtor) > max_iv &&
                        (now - last_fake) > fake_gap && !pulse_high) begin
                        rhythm    = RHY_UNSTABLE;
                        last_fake = now;
                        start_pulse(r, interval_t'(fake_gap));
                        fakes++;
                    end else if (!contact)
                        rhythm = RHY_UNKNOWN;
                    if ((now - pulse_t0) >= width)
                        pulse_high = 1'b0;
                end
                OP_RTOR: begin
                    iv = {rw[23:10], 3'b000};
                    if (iv >= min_iv && iv <= max_iv) begin
                        last_rtor = now;
                        if (contact) begin
                            rhythm = RHY_STABLE;
                            start_pulse(r, iv);
                        end
                    end
                end
                OP_FIFO: begin
                    tag      = fw[5:3];
                    r.sample = fw[23:8];
                    if (burst_len < BURST_MAX) begin
                        burst_len++;
                        if (r.sample >= top || r.sample <= bottom)
                            burst_on++;
                        else
                            burst_off++;
                    end
                    if (tag != TAG_VALID && tag != TAG_FAST) begin
                        r.burst_end  = 1'b1;
                        r.fifo_reset = (tag == TAG_OVERFLOW);
                        if (burst_len > 1) begin
                            on_total  = sat_add(on_total, burst_on);
                            off_total = sat_add(off_total, burst_off);
                        end
                        bursts++;
                        if (bursts >= batch) begin
                            thr       = (5 * burst_len) >> 1;
                            contact   = (on_total > min_on) && (off_total > thr);
                            on_total  = '0;
                            off_total = '0;
                            bursts    = '0;
                            r.batch_done = 1'b1;
                            decisions++;
                            if (contact)
                                contact_on++;
                        end
                        burst_on  = '0;
                        burst_off = '0;
                        burst_len = '0;
                    end
                end
                default: ;
            endcase
            r.pulse_level    = pulse_high;
            r.contact_status = contact;
            r.rhythm         = rhythm;
            expected_status.push_back(r);
        endfunction

        function void check_field(string name, logic signed [31:0] e, logic signed [31:0] a);
            if (a !== e) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_status(status_t got);
            status_t want;
            if (expected_status.size() == 0) begin
                $display("%0t: result transfer with no item outstanding", $time);
                errors++;
                return;
            end
            want = expected_status.pop_front();
            checked++;
            check_field("pulse_level", want.pulse_level, got.pulse_level);
            check_field("pulse_started", want.pulse_started, got.pulse_started);
            check_field("pulse_interval_ms", want.interval, got.interval);
            check_field("contact_status", want.contact_status, got.contact_status);
            check_field("rhythm_status", want.rhythm, got.rhythm);
            check_field("sample_value", want.sample, got.sample);
            check_field("burst_end", want.burst_end, got.burst_end);
            check_field("fifo_reset", want.fifo_reset, got.fifo_reset);
            check_field("batch_done", want.batch_done, got.batch_done);
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    op_t       op        = '0;
    word_t     rtor_word = '0;
    word_t     fifo_word = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    logic      pulse_level, pulse_started, contact_status;
    interval_t pulse_interval_ms;
    rhythm_t   rhythm_status;
    sample_t   sample_value;
    logic      burst_end, fifo_reset, batch_done;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    contact_pulse_tracker sb;
    status_t seen;
    int  items_sent   = 0;
    int  delivered    = 0;
    int  stall_cycles = 0;
    bit  steady       = 1'b0;   // no idling on either side while set
    bit  held         = 1'b0;   // long receiver hold-off already done

    ecg_heart_pulse_and_contact_detector_core DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .op                (op),
        .rtor_word         (rtor_word),
        .fifo_word         (fifo_word),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .pulse_level       (pulse_level),
        .pulse_started     (pulse_started),
        .pulse_interval_ms (pulse_interval_ms),
        .contact_status    (contact_status),
        .rhythm_status     (rhythm_status),
        .sample_value      (sample_value),
        .burst_end         (burst_end),
        .fifo_reset        (fifo_reset),
        .batch_done        (batch_done),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #5 clk = ~clk;

    // Build a FIFO word; the unused bits get random values.
    function automatic word_t fifo_of(sample_t s, logic [2:0] tag);
        return {s, 2'($urandom), tag, 3'($urandom)};
    endfunction

    // Pick a sample between the band limits, edges included, or anywhere at all.
    function automatic sample_t pick_sample(bit in_band);
        int lo, hi;
        lo = sb.bottom;
        hi = sb.top;
        if (in_band && hi >= lo)
            return sample_t'(lo + int'($urandom_range(hi - lo)));
        return sample_t'($urandom);
    endfunction

    // R-to-R word whose interval lies inside the current limits, if any does.
    function automatic word_t valid_rtor();
        int lo, hi;
        lo = (sb.min_iv + 7) / 8;
        hi = sb.max_iv / 8;
        if (hi > 16383)
            hi = 16383;
        if (lo > hi)
            return word_t'($urandom);
        return {14'($urandom_range(hi, lo)), 10'($urandom)};
    endfunction

    // Offer one item and hold it until it transfers; idle first at random.
    task automatic send_item(op_t o, word_t rw, word_t fw);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 22) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= o;
        rtor_word <= rw;
        fifo_word <= fw;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.take_item(o, rw, fw);
        items_sent++;
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [16:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        sb.set_reg(idx, v);
    endtask

    // Drain the block, then load a full register setting.
    task automatic load_setting(interval_t mn, interval_t mx, ms16_t wd, ms16_t fk,
                                sample_t tp, sample_t bt, batch_t bs, cnt16_t mo);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_status.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        write_reg(REG_MIN_INTERVAL, mn);
        write_reg(REG_MAX_INTERVAL, mx);
        write_reg(REG_PULSE_WIDTH, {1'b0, wd});
        write_reg(REG_FAKE_INTERVAL, {1'b0, fk});
        write_reg(REG_BAND_TOP, {1'b0, tp});
        write_reg(REG_BAND_BOTTOM, {1'b0, bt});
        write_reg(REG_BATCH_SIZE, {13'd0, bs});
        write_reg(REG_ON_MIN_COUNT, {1'b0, mo});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // One burst of FIFO words; a broken burst stops without an end tag.
    task automatic send_burst(int len, int off_pct, bit broken);
        logic [2:0] tag;
        for (int i = 0; i < len; i++) begin
            if (i == len - 1 && !broken)
                tag = 3'($urandom_range(TAG_OVERFLOW, TAG_FAST + 1));
            else
                tag = 3'($urandom_range(TAG_FAST, TAG_VALID));
            send_item(OP_FIFO, word_t'($urandom),
                      fifo_of(pick_sample($urandom_range(99) < off_pct), tag));
        end
    endtask

    // Mostly well-formed traffic: bursts, tick runs and in-range intervals,
    // with some broken bursts and plain noise mixed in.
    task automatic run_traffic(int n);
        int first, pick, len;
        first = items_sent;
        while (items_sent - first < n) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                len = ($urandom_range(19) == 0) ? $urandom_range(40, 30) : $urandom_range(6, 1);
                send_burst(len, 75, $urandom_range(9) == 0);
            end else if (pick < 80) begin
                len = $urandom_range(50, 1);
                repeat (len) send_item(OP_TICK, word_t'($urandom), word_t'($urandom));
            end else if (pick < 95) begin
                send_item(OP_RTOR, ($urandom_range(3) == 0) ? word_t'($urandom) : valid_rtor(),
                          word_t'($urandom));
            end else
                send_item(op_t'($urandom_range(2)), word_t'($urandom), word_t'($urandom));
        end
    endtask

    // Receiver: stall at random, and hold off once for a long stretch so
    // the output register fills and the block stops taking input.
    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!held && delivered >= 200) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (59) @(negedge clk);
            end else
                out_ready <= steady || ($urandom_range(99) >= 22);
        end
    end

    // Check every result transfer against the oldest outstanding item.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            seen.pulse_level    = pulse_level;
            seen.pulse_started  = pulse_started;
            seen.interval       = pulse_interval_ms;
            seen.contact_status = contact_status;
            seen.rhythm         = rhythm_status;
            seen.sample         = sample_value;
            seen.burst_end      = burst_end;
            seen.fifo_reset     = fifo_reset;
            seen.batch_done     = batch_done;
            sb.check_status(seen);
            delivered++;
        end
    end

    // Watchdog: drop the run if neither channel moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("ecg_heart_pulse_and_contact_detector_core regression: fail");
            $finish;
        end
    end

    initial begin
        sb = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at reset values: spare op, interval extremes, sample
        // extremes and band edges, an overflow reset, single-word bursts and
        // one full batch decision.
        send_item(OP_SPARE, 24'hFFFFFF, 24'hFFFFFF);
        send_item(OP_TICK, '0, '0);
        send_item(OP_RTOR, 24'h000000, '0);
        send_item(OP_RTOR, 24'hFFFFFF, '0);
        send_item(OP_RTOR, {14'd64, 10'h3FF}, '0);
        send_item(OP_FIFO, '0, fifo_of(16'sh7FFF, TAG_VALID));
        send_item(OP_FIFO, '0, fifo_of(-16'sh8000, TAG_FAST));
        send_item(OP_FIFO, '0, fifo_of(-16'sd8, TAG_VALID));
        send_item(OP_FIFO, '0, fifo_of(-16'sd25, TAG_FAST));
        send_item(OP_FIFO, '0, fifo_of(-16'sd16, TAG_OVERFLOW));
        send_item(OP_FIFO, '0, 24'hFFFFFF);
        send_item(OP_FIFO, '0, 24'h000000);
        for (int t = TAG_FAST + 1; t < TAG_OVERFLOW; t++)
            send_item(OP_FIFO, '0, fifo_of(-16'sd12, 3'(t)));
        send_item(OP_TICK, '0, '0);
        send_item(OP_TICK, '0, '0);
        send_item(OP_RTOR, {14'd64, 10'h000}, '0);

        // Short intervals so real and fake pulses both occur often
        load_setting(17'd16, 17'd80, 16'd10, 16'd30, 16'sd300, -16'sd300, 4'd6, 16'd1);
        run_traffic(750);

        // Upper extremes: every interval valid, pulse never falls, no contact
        load_setting(17'd0, 17'd131071, 16'd65535, 16'd65535,
                     16'sh7FFF, -16'sh8000, 4'd15, 16'd65535);
        run_traffic(200);

        // Lower extremes: no valid interval, empty band, batch size zero
        load_setting(17'd131071, 17'd0, 16'd1, 16'd1, -16'sh8000, 16'sh7FFF, 4'd0, 16'd0);
        run_traffic(200);

        // Zero pulse width, run back to back with no idling
        load_setting(17'd8, 17'd40, 16'd0, 16'd5, 16'sd1000, -16'sd1000, 4'd4, 16'd0);
        steady = 1'b1;
        run_traffic(450);
        steady = 1'b0;

        // Narrow band equal to the reset band
        load_setting(17'd24, 17'd120, 16'd50, 16'd60, -16'sd8, -16'sd25, 4'd3, 16'd2);
        run_traffic(350);

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d items, %0d results checked over six register settings",
                 sb.items, sb.checked);
        $display("%0d pulses (%0d fake), %0d contact decisions (%0d in contact), %0d mismatches",
                 sb.pulses, sb.fakes, sb.decisions, sb.contact_on, sb.errors);
        if (sb.errors == 0)
            $display("ecg_heart_pulse_and_contact_detector_core regression: pass");
        else
            $display("ecg_heart_pulse_and_contact_detector_core regression: fail");
        $finish;
    end
endmodule
